@@ hdl/rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtp_pkg
// shared types and constants of the relay timer pulse controller
// ----------------------------------------------------------------------------
package rtp_pkg;

	localparam int unsigned MS_PER_S = 1000;
	localparam int unsigned PHASE_W  = 10;
	localparam int unsigned AMOUNT_W = 17;
	localparam int unsigned PULSE_W  = 16;
	localparam int unsigned TIMER_W  = 17;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned DATA_W   = 32;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_OFF    = 3'd1,
		OP_ON     = 3'd2,
		OP_TOGGLE = 3'd3,
		OP_PULSE  = 3'd4,
		OP_TSTART = 3'd5,
		OP_TSTOP  = 3'd6,
		OP_CLEAR  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		REG_INVERT  = 2'd0,
		REG_PULSE   = 2'd1,
		REG_TIMER   = 2'd2,
		REG_UNUSED  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                  output_inverted;
		logic [PULSE_W-1:0]    pulse_dflt_ms;
		logic [TIMER_W-1:0]    default_timer_s;
	} cfg_t;

	localparam logic [PULSE_W-1:0] DEF_PULSE_MS = 16'd500;
	localparam logic [TIMER_W-1:0] DEF_TIMER_S  = 17'd60;

endpackage

@@ hdl/rtp_cfg.sv @@
// ----------------------------------------------------------------------------
// rtp_cfg
// apb register file holding polarity and default lengths
// ----------------------------------------------------------------------------
module rtp_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rtp_pkg::ADDR_W-1:0] paddr,
	input  logic [rtp_pkg::DATA_W-1:0] pwdata,
	output logic [rtp_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rtp_pkg::cfg_t              cfg
);
	import rtp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_inverted  <= 1'b0;
			cfg_q.pulse_dflt_ms    <= DEF_PULSE_MS;
			cfg_q.default_timer_s  <= DEF_TIMER_S;
		end else if (wr_en) begin
			case (idx)
				REG_INVERT: cfg_q.output_inverted  <= pwdata[0];
				REG_PULSE:  cfg_q.pulse_dflt_ms    <= pwdata[PULSE_W-1:0];
				REG_TIMER:  cfg_q.default_timer_s  <= pwdata[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_INVERT: prdata = {{(DATA_W-1){1'b0}}, cfg_q.output_inverted};
			REG_PULSE:  prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_q.pulse_dflt_ms};
			REG_TIMER:  prdata = {{(DATA_W-TIMER_W){1'b0}}, cfg_q.default_timer_s};
			default:    prdata = '0;
		endcase
	end

endmodule

@@ hdl/relay_timer_pulse_controller.sv @@
// ----------------------------------------------------------------------------
// relay_timer_pulse_controller
// relay state, pulse and timer expiry, on-time and switch counters
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   op, amount
// m_*       out  m_tvalid/m_tready   relay_on .. switches
// apb       in   psel/penable        output_inverted, pulse_dflt_ms,
//                                    default_timer_s
//
// one request per cycle while s_tready is high, result in the cycle after acceptance
// the state update and result are one pass of logic into the output register
// s_tready is high while the output register is empty or being drained
// reset gives relay off, no timer or pulse, counters zero, defaults 500 ms / 60 s
// ----------------------------------------------------------------------------
module relay_timer_pulse_controller #(
	parameter int unsigned PULSE_MIN_MS = 10,
	parameter int unsigned PULSE_MAX_MS = 60000,
	parameter int unsigned TIMER_MIN_S  = 1,
	parameter int unsigned TIMER_MAX_S  = 86400
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// op [2:0], amount [19:3]
	input  logic [23:0]                s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// relay_on [0], drive_level [1], changed [2], timer_running [3],
	// pulse_running [4], timer_left_s [21:5], on_seconds [53:22], switches [85:54]
	output logic [87:0]                m_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rtp_pkg::ADDR_W-1:0] paddr,
	input  logic [rtp_pkg::DATA_W-1:0] pwdata,
	output logic [rtp_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import rtp_pkg::*;

	cfg_t cfg;

	rtp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	localparam logic [AMOUNT_W-1:0] P_MIN = AMOUNT_W'(PULSE_MIN_MS);
	localparam logic [AMOUNT_W-1:0] P_MAX = AMOUNT_W'(PULSE_MAX_MS);
	localparam logic [AMOUNT_W-1:0] T_MIN = AMOUNT_W'(TIMER_MIN_S);
	localparam logic [AMOUNT_W-1:0] T_MAX = AMOUNT_W'(TIMER_MAX_S);
	localparam logic [PHASE_W-1:0]  MS_LAST = PHASE_W'(MS_PER_S - 1);

	logic                relay_q, relay_d;
	logic                timer_on_q, timer_on_d;
	logic                pulse_on_q, pulse_on_d;
	logic [TIMER_W-1:0]  t_sec_q, t_sec_d;
	logic [PHASE_W-1:0]  t_ms_q, t_ms_d;
	logic [PULSE_W-1:0]  p_left_q, p_left_d;
	logic [PHASE_W-1:0]  phase_q, phase_d;
	logic [COUNT_W-1:0]  on_sec_q, on_sec_d;
	logic [COUNT_W-1:0]  sw_q, sw_d;
	logic                m_valid_q;
	logic [87:0]         m_tdata_q;

	op_t                 op;
	logic [AMOUNT_W-1:0] amount;
	logic [AMOUNT_W-1:0] p_sel, t_sel, p_clamp, t_clamp;
	logic                accept, changed;
	logic [TIMER_W-1:0]  left_s;

	assign op       = op_t'(s_tdata[2:0]);
	assign amount   = s_tdata[19:3];
	assign s_tready = ~m_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_tdata_q;

	assign p_sel = (amount != '0) ? amount : {1'b0, cfg.pulse_dflt_ms};
	assign t_sel = (amount != '0) ? amount : cfg.default_timer_s;

	always_comb begin
		p_clamp = p_sel;
		if (p_sel < P_MIN) p_clamp = P_MIN;
		if (p_sel > P_MAX) p_clamp = P_MAX;
		t_clamp = t_sel;
		if (t_sel < T_MIN) t_clamp = T_MIN;
		if (t_sel > T_MAX) t_clamp = T_MAX;
	end

	always_comb begin
		relay_d    = relay_q;
		timer_on_d = timer_on_q;
		pulse_on_d = pulse_on_q;
		t_sec_d    = t_sec_q;
		t_ms_d     = t_ms_q;
		p_left_d   = p_left_q;
		phase_d    = phase_q;
		on_sec_d   = on_sec_q;
		case (op)
			OP_TICK: begin
				if (phase_q == MS_LAST) begin
					phase_d = '0;
					if (relay_q) on_sec_d = on_sec_q + 1'b1;
				end else begin
					phase_d = phase_q + 1'b1;
				end
				if (timer_on_q) begin
					if (t_ms_q != '0) begin
						t_ms_d = t_ms_q - 1'b1;
					end else if (t_sec_q != '0) begin
						t_sec_d = t_sec_q - 1'b1;
						t_ms_d  = MS_LAST;
					end
					if (t_sec_d == '0 && t_ms_d == '0) begin
						relay_d    = 1'b0;
						timer_on_d = 1'b0;
					end
				end
				if (pulse_on_q) begin
					if (p_left_q != '0) p_left_d = p_left_q - 1'b1;
					if (p_left_d == '0) begin
						relay_d    = 1'b0;
						pulse_on_d = 1'b0;
					end
				end
			end
			OP_OFF:    relay_d = 1'b0;
			OP_ON:     relay_d = 1'b1;
			OP_TOGGLE: relay_d = ~relay_q;
			OP_PULSE: begin
				pulse_on_d = 1'b1;
				p_left_d   = p_clamp[PULSE_W-1:0];
				relay_d    = 1'b1;
			end
			OP_TSTART: begin
				timer_on_d = 1'b1;
				t_sec_d    = t_clamp;
				t_ms_d     = '0;
				relay_d    = 1'b1;
			end
			OP_TSTOP: timer_on_d = 1'b0;
			OP_CLEAR: on_sec_d = '0;
			default: ;
		endcase
	end

	assign changed = relay_d ^ relay_q;
	assign sw_d    = (op == OP_CLEAR) ? '0 : sw_q + {{(COUNT_W-1){1'b0}}, changed};
	assign left_s  = timer_on_d ? t_sec_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q    <= 1'b0;
			timer_on_q <= 1'b0;
			pulse_on_q <= 1'b0;
			t_sec_q    <= '0;
			t_ms_q     <= '0;
			p_left_q   <= '0;
			phase_q    <= '0;
			on_sec_q   <= '0;
			sw_q       <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				relay_q    <= relay_d;
				timer_on_q <= timer_on_d;
				pulse_on_q <= pulse_on_d;
				t_sec_q    <= t_sec_d;
				t_ms_q     <= t_ms_d;
				p_left_q   <= p_left_d;
				phase_q    <= phase_d;
				on_sec_q   <= on_sec_d;
				sw_q       <= sw_d;
			end
			if (accept) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {2'b00, sw_d, on_sec_d, left_s, pulse_on_d, timer_on_d,
				changed, relay_d ^ cfg.output_inverted, relay_d};
		end
	end

endmodule
